@@ design/assert_macros.svh @@
// ---------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms for the bigram counter blocks.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define ASSERT_SAME(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed");

// The consequent must hold in the cycle after the antecedent.
`define ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

@@ design/bfc_pkg.sv @@
// ---------------------------------------------------------------------------
// Bigram counter package
// Sizes, request codes, controller states, the command/status bundles and a clamp.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

package bfc_pkg;

  localparam int MAX_SYMBOLS = 256;
  localparam int SYM_W = 16;
  // Address width of the symbol store, and width of the symbol count.
  localparam int AW = (MAX_SYMBOLS > 2) ? $clog2(MAX_SYMBOLS) : 1;
  localparam int NW = AW + 1;

  localparam logic [1:0] REQ_APPEND  = 2'd0;
  localparam logic [1:0] REQ_QUERY   = 2'd1;
  localparam logic [1:0] REQ_RESTART = 2'd2;
  localparam logic [1:0] REQ_UNUSED  = 2'd3;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_WRITE,
    ST_SCAN,
    ST_RESULT
  } state_t;

  typedef struct packed {
    logic load;
    logic write;
    logic scan;
    logic finish;
    logic emit;
  } dp_cmd_t;

  typedef struct packed {
    logic full;
    logic has_symbol;
    logic scan_done;
  } dp_sts_t;

  // Clamp a count to the 8-bit result fields.
  function automatic logic [7:0] sat8(input logic [NW-1:0] v);
    logic [NW+7:0] w;
    w = {8'd0, v};
    return (w > (NW + 8)'(255)) ? 8'hFF : w[7:0];
  endfunction

endpackage

@@ design/bigram_frequency_counter.sv @@
// Throughput: one request at a time; the pair scan reads the single-port symbol RAM
// once per cycle.
// Reset (synchronous, active high) empties the sequence and clears the maximum;
// the symbol RAM itself is not cleared and needs no clearing pass.
// ---------------------------------------------------------------------------
// Bigram frequency counter
// Stores a symbol sequence, answers pair count queries and tracks the most
// frequent adjacent pair.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module bigram_frequency_counter (
  input  logic        clk,
  input  logic        rst,
  // Request channel.
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [1:0]  req_type,
  input  logic [15:0] symbol,
  input  logic [15:0] query_first,
  input  logic [15:0] query_second,
  // Result channel.
  output logic        out_valid,
  input  logic        out_ready,
  output logic [7:0]  pair_count,
  output logic [7:0]  total_bigrams,
  output logic        max_valid,
  output logic [15:0] max_first,
  output logic [15:0] max_second,
  output logic [7:0]  max_count,
  output logic        overflow
);

  import bfc_pkg::*;

  // Each request transfer is processed in turn. An append writes the new symbol
  // into the store, then one pass over all stored pairs counts the new bigram
  // and finds its first occurrence. Only that bigram's count changed, so the
  // running maximum is replaced when its count is larger, or equal with an
  // earlier first occurrence. A query runs the same pass for the named pair.
  // The finished result sits in an output register, so the next request can
  // be taken while the previous result waits for its transfer.

  dp_cmd_t cmd;
  dp_sts_t sts;

  bfc_controller u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .req_type (req_type),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .cmd      (cmd),
    .sts      (sts)
  );

  bfc_datapath u_dp (
    .clk          (clk),
    .rst          (rst),
    .cmd          (cmd),
    .sts          (sts),
    .req_type     (req_type),
    .symbol       (symbol),
    .query_first  (query_first),
    .query_second (query_second),
    .pair_count   (pair_count),
    .total_bigrams(total_bigrams),
    .max_valid    (max_valid),
    .max_first    (max_first),
    .max_second   (max_second),
    .max_count    (max_count),
    .overflow     (overflow)
  );

endmodule

@@ design/bfc_ram.sv @@
// ---------------------------------------------------------------------------
// Generic single-port RAM
// One read or write per cycle; read data is registered.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module bfc_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 256
) (
  input  logic                                         clk,
  input  logic                                         we,
  input  logic [((DEPTH > 2) ? $clog2(DEPTH) : 1)-1:0] addr,
  input  logic [WIDTH-1:0]                             wdata,
  output logic [WIDTH-1:0]                             rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end

endmodule

@@ design/bfc_datapath.sv @@
// ---------------------------------------------------------------------------
// Bigram counter datapath
// Symbol store, pair scan, incremental maximum tracking and result register.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

`include "assert_macros.svh"

module bfc_datapath (
  input  logic                     clk,
  input  logic                     rst,
  input  bfc_pkg::dp_cmd_t         cmd,
  output bfc_pkg::dp_sts_t         sts,
  input  logic [1:0]               req_type,
  input  logic [bfc_pkg::SYM_W-1:0] symbol,
  input  logic [bfc_pkg::SYM_W-1:0] query_first,
  input  logic [bfc_pkg::SYM_W-1:0] query_second,
  output logic [7:0]               pair_count,
  output logic [7:0]               total_bigrams,
  output logic                     max_valid,
  output logic [15:0]              max_first,
  output logic [15:0]              max_second,
  output logic [7:0]               max_count,
  output logic                     overflow
);

  import bfc_pkg::*;

  // Sequence state.
  logic [NW-1:0]    count;
  logic [SYM_W-1:0] last_sym;

  // Current request.
  logic [1:0]       op;
  logic [SYM_W-1:0] tgt_a;
  logic [SYM_W-1:0] tgt_b;
  logic             ovf;
  logic [AW-1:0]    pc;

  // Scan state.
  logic [NW-1:0]    scan_addr;
  logic             rd_pend;
  logic [AW-1:0]    rd_idx;
  logic [SYM_W-1:0] prev;
  logic [AW-1:0]    hits;
  logic [AW-1:0]    hit_first;

  // Most frequent bigram so far.
  logic [AW-1:0]    best_cnt;
  logic [AW-1:0]    best_idx;
  logic [SYM_W-1:0] best_a;
  logic [SYM_W-1:0] best_b;

  logic             issue;
  logic [AW-1:0]    ram_addr;
  logic [SYM_W-1:0] rd_data;
  logic             pair_hit;
  logic             take_best;
  logic [NW-1:0]    total;

  assign issue    = cmd.scan && (scan_addr < count);
  assign ram_addr = cmd.write ? count[AW-1:0] : scan_addr[AW-1:0];
  assign pair_hit = rd_pend && (rd_idx != '0) && (prev == tgt_a) && (rd_data == tgt_b);
  // Ties go to the bigram whose first occurrence is earlier.
  assign take_best = (hits > best_cnt) || ((hits == best_cnt) && (hit_first < best_idx));
  assign total     = (count >= NW'(2)) ? (count - NW'(1)) : '0;

  assign sts.full       = (count == NW'(MAX_SYMBOLS));
  assign sts.has_symbol = (count != '0);
  assign sts.scan_done  = (scan_addr >= count) && !rd_pend;

  bfc_ram #(
    .WIDTH(SYM_W),
    .DEPTH(MAX_SYMBOLS)
  ) u_store (
    .clk  (clk),
    .we   (cmd.write),
    .addr (ram_addr),
    .wdata(tgt_b),
    .rdata(rd_data)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      count    <= '0;
      best_cnt <= '0;
      rd_pend  <= 1'b0;
    end else begin
      if (cmd.load) begin
        rd_pend <= 1'b0;
        if (req_type == REQ_RESTART) begin
          count    <= '0;
          best_cnt <= '0;
        end
      end else begin
        rd_pend <= issue;
      end
      if (cmd.write) begin
        count <= count + NW'(1);
      end
      if (cmd.finish && (op == REQ_APPEND) && take_best) begin
        best_cnt <= hits;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      op        <= req_type;
      ovf       <= (req_type == REQ_APPEND) && sts.full;
      pc        <= '0;
      scan_addr <= '0;
      hits      <= '0;
      hit_first <= '0;
      if (req_type == REQ_APPEND) begin
        tgt_a <= last_sym;
        tgt_b <= symbol;
      end else begin
        tgt_a <= query_first;
        tgt_b <= query_second;
      end
    end
    if (cmd.write) begin
      last_sym <= tgt_b;
    end
    if (issue) begin
      scan_addr <= scan_addr + NW'(1);
      rd_idx    <= scan_addr[AW-1:0];
    end
    if (rd_pend) begin
      prev <= rd_data;
    end
    if (pair_hit) begin
      hits <= hits + AW'(1);
      if (hits == '0) begin
        hit_first <= rd_idx - AW'(1);
      end
    end
    if (cmd.finish) begin
      if (op == REQ_QUERY) begin
        pc <= hits;
      end
      if ((op == REQ_APPEND) && take_best) begin
        best_idx <= hit_first;
        best_a   <= tgt_a;
        best_b   <= tgt_b;
      end
    end
    if (cmd.emit) begin
      pair_count    <= sat8({1'b0, pc});
      total_bigrams <= sat8(total);
      max_valid     <= (best_cnt != '0);
      max_first     <= (best_cnt != '0) ? best_a : '0;
      max_second    <= (best_cnt != '0) ? best_b : '0;
      max_count     <= sat8({1'b0, best_cnt});
      overflow      <= ovf;
    end
  end

  `ASSERT_SAME(a_count_bound, clk, rst, 1'b1, count <= NW'(MAX_SYMBOLS))
  `ASSERT_SAME(a_best_needs_pair, clk, rst, best_cnt != '0, count >= NW'(2))
  `ASSERT_SAME(a_read_in_range, clk, rst, rd_pend, NW'(rd_idx) < count)

endmodule

@@ design/bfc_controller.sv @@
// ---------------------------------------------------------------------------
// Bigram counter controller
// Sequences write, scan and result steps for one request at a time.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

`include "assert_macros.svh"

module bfc_controller (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  output logic             in_ready,
  input  logic [1:0]       req_type,
  output logic             out_valid,
  input  logic             out_ready,
  output bfc_pkg::dp_cmd_t cmd,
  input  bfc_pkg::dp_sts_t sts
);

  import bfc_pkg::*;

  state_t state;
  state_t state_next;
  logic   out_valid_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      out_valid <= out_valid_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd        = '0;
    in_ready   = 1'b0;
    case (state)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load = 1'b1;
          case (req_type)
            REQ_APPEND:  state_next = sts.full ? ST_RESULT : ST_WRITE;
            REQ_QUERY:   state_next = ST_SCAN;
            REQ_RESTART: state_next = ST_RESULT;
            default:     state_next = ST_RESULT;
          endcase
        end
      end
      ST_WRITE: begin
        cmd.write  = 1'b1;
        // A first symbol forms no pair, so there is nothing to rescan.
        state_next = sts.has_symbol ? ST_SCAN : ST_RESULT;
      end
      ST_SCAN: begin
        cmd.scan = 1'b1;
        if (sts.scan_done) begin
          cmd.finish = 1'b1;
          state_next = ST_RESULT;
        end
      end
      ST_RESULT: begin
        if (!out_valid || out_ready) begin
          cmd.emit   = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    if (cmd.emit) begin
      out_valid_next = 1'b1;
    end else if (out_ready) begin
      out_valid_next = 1'b0;
    end else begin
      out_valid_next = out_valid;
    end
  end

  `ASSERT_NEXT(a_one_in_flight, clk, rst, in_valid && in_ready, !in_ready)
  `ASSERT_SAME(a_emit_slot_free, clk, rst, cmd.emit, !out_valid || out_ready)
  `ASSERT_NEXT(a_emit_shows, clk, rst, cmd.emit, out_valid)

endmodule

@@ tb/bigram_frequency_counter_tb.sv @@
// ---------------------------------------------------------------------------
// Bigram frequency counter testbench
// Drives append, count, restart and unused requests into the counter and
// compares every result against a behavioral model of the symbol sequence,
// under several sender and receiver idling patterns.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module bigram_frequency_counter_tb;

  import bfc_pkg::*;

  // Cycles without any transfer before the run is declared hung. The longest
  // legal quiet stretch is the receiver hold-off plus one full-store scan.
  localparam int WATCHDOG_LIMIT = 5000;
  // Receiver hold-off used by the backpressure test.
  localparam int HOLD_OFF_CYCLES = 600;
  // Quiet cycles after the last result, a bit more than one full-store scan.
  localparam int TAIL_CYCLES = 300;

  // One result transfer, field by field.
  typedef struct packed {
    logic [7:0]  pair_count;
    logic [7:0]  total_bigrams;
    logic        max_valid;
    logic [15:0] max_first;
    logic [15:0] max_second;
    logic [7:0]  max_count;
    logic        overflow;
  } bigram_stats_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [1:0]  req_type = REQ_APPEND;
  logic [15:0] symbol = '0;
  logic [15:0] query_first = '0;
  logic [15:0] query_second = '0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [7:0]  pair_count;
  logic [7:0]  total_bigrams;
  logic        max_valid;
  logic [15:0] max_first;
  logic [15:0] max_second;
  logic [7:0]  max_count;
  logic        overflow;

  bigram_frequency_counter dut (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .req_type     (req_type),
    .symbol       (symbol),
    .query_first  (query_first),
    .query_second (query_second),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .pair_count   (pair_count),
    .total_bigrams(total_bigrams),
    .max_valid    (max_valid),
    .max_first    (max_first),
    .max_second   (max_second),
    .max_count    (max_count),
    .overflow     (overflow)
  );

  always #4 clk = ~clk;

  // Model of the stored sequence. It advances only when a request transfer
  // is seen, so it always mirrors what the block has accepted so far.
  logic [15:0]   seq_mem [MAX_SYMBOLS];
  int            seq_len = 0;
  bigram_stats_t bigram_stats_q[$];

  int mismatch_count = 0;
  int send_idle_pct = 0;
  int recv_stall_pct = 0;

  // The backpressure test flips this bit; the receiver process notices the
  // change and counts out its own hold-off.
  logic hold_off_req = 1'b0;
  logic hold_off_seen = 1'b0;
  int   hold_left = 0;
  int   quiet_cycles = 0;

  bigram_stats_t arrived;
  bigram_stats_t oldest;

  function automatic logic [7:0] clamp8(input int v);
    return (v > 255) ? 8'd255 : 8'(v);
  endfunction

  // Applies one request to the sequence model and returns the result the
  // block must produce for it. Pairs are tallied first, then scanned in
  // order with a strict greater-than so that the earliest pair wins ties.
  function automatic bigram_stats_t predict_bigram_stats(input logic [1:0] kind,
                                                         input logic [15:0] sym,
                                                         input logic [15:0] qa,
                                                         input logic [15:0] qb);
    bigram_stats_t r;
    int            tally [logic [31:0]];
    logic [31:0]   key;
    int            hits;
    int            best;
    r = '0;
    hits = 0;
    best = 0;
    if (kind == REQ_APPEND) begin
      if (seq_len < MAX_SYMBOLS) begin
        seq_mem[seq_len] = sym;
        seq_len++;
      end else begin
        r.overflow = 1'b1;
      end
    end else if (kind == REQ_RESTART) begin
      seq_len = 0;
    end
    for (int i = 0; i + 1 < seq_len; i++) begin
      key = {seq_mem[i], seq_mem[i + 1]};
      if (tally.exists(key)) tally[key]++;
      else tally[key] = 1;
      if (kind == REQ_QUERY && key == {qa, qb}) hits++;
    end
    for (int i = 0; i + 1 < seq_len; i++) begin
      key = {seq_mem[i], seq_mem[i + 1]};
      if (tally[key] > best) begin
        best = tally[key];
        r.max_first = seq_mem[i];
        r.max_second = seq_mem[i + 1];
      end
    end
    r.pair_count = clamp8(hits);
    r.total_bigrams = (seq_len >= 2) ? clamp8(seq_len - 1) : 8'd0;
    r.max_valid = (best > 0);
    r.max_count = clamp8(best);
    return r;
  endfunction

  // Offers one request and returns at the falling edge after its transfer.
  // The caller is always at a falling edge, so valid is changed there only.
  task automatic send_request(input logic [1:0] kind, input logic [15:0] sym,
                              input logic [15:0] qa, input logic [15:0] qb);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid = 1'b0;
      @(negedge clk);
    end
    in_valid = 1'b1;
    req_type = kind;
    symbol = sym;
    query_first = qa;
    query_second = qb;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    bigram_stats_q.push_back(predict_bigram_stats(kind, sym, qa, qb));
    @(negedge clk);
  endtask

  // Fields that a request does not use carry random bits, so every input bit
  // toggles even in the directed tests.
  task automatic append_symbol(input logic [15:0] sym);
    send_request(REQ_APPEND, sym, 16'($urandom), 16'($urandom));
  endtask

  task automatic query_pair(input logic [15:0] qa, input logic [15:0] qb);
    send_request(REQ_QUERY, 16'($urandom), qa, qb);
  endtask

  task automatic restart_sequence();
    send_request(REQ_RESTART, 16'($urandom), 16'($urandom), 16'($urandom));
  endtask

  // The sender stops and waits until every predicted result has arrived.
  task automatic wait_for_results();
    in_valid = 1'b0;
    while (bigram_stats_q.size() != 0) @(negedge clk);
  endtask

  task automatic check_field(input string name, input int want, input int got);
    if (want != got) begin
      $display("%0t: %s mismatch, expected %0d (0x%0h), actual %0d (0x%0h)",
               $time, name, want, want, got, got);
      mismatch_count++;
    end
  endtask

  // Requests on an empty store, the unused selector, and a single symbol,
  // none of which has a bigram to report.
  task automatic test_empty_and_unused();
    query_pair(16'h0000, 16'h0000);
    send_request(REQ_UNUSED, 16'hFFFF, 16'hFFFF, 16'hFFFF);
    restart_sequence();
    append_symbol(16'h8000);
    query_pair(16'h8000, 16'h8000);
    send_request(REQ_UNUSED, 16'h0000, 16'h0000, 16'h0000);
    wait_for_results();
  endtask

  // Extreme symbol values, earliest-first tie breaking, a later pair that
  // overtakes, and a restart that hides the old contents.
  task automatic test_pair_ordering();
    restart_sequence();
    append_symbol(16'hFFFF);
    append_symbol(16'h0000);
    append_symbol(16'hFFFF);
    append_symbol(16'h0000);
    query_pair(16'hFFFF, 16'h0000);
    query_pair(16'h0000, 16'h0000);
    restart_sequence();
    append_symbol(16'h0001);
    append_symbol(16'h0002);
    append_symbol(16'h0003);
    append_symbol(16'h0002);
    append_symbol(16'h0003);
    query_pair(16'h0002, 16'h0003);
    restart_sequence();
    query_pair(16'h0001, 16'h0002);
    append_symbol(16'h0007);
    append_symbol(16'h0007);
    query_pair(16'h0007, 16'h0007);
    wait_for_results();
  endtask

  // A store filled with one symbol gives the largest counts the result
  // fields can hold. Appends past the end are dropped and flagged, and the
  // flag clears on the next request.
  task automatic test_store_full();
    restart_sequence();
    for (int i = 0; i < MAX_SYMBOLS; i++) append_symbol(16'hA5A5);
    query_pair(16'hA5A5, 16'hA5A5);
    append_symbol(16'h5A5A);
    append_symbol(16'hFFFF);
    send_request(REQ_UNUSED, 16'h1234, 16'h5678, 16'h9ABC);
    query_pair(16'hA5A5, 16'h5A5A);
    restart_sequence();
    wait_for_results();
  endtask

  // The receiver holds off for a long stretch while the sender keeps
  // offering, so the block fills and drops in_ready. Afterwards the sender
  // waits until all results are in.
  task automatic test_backpressure();
    send_idle_pct = 0;
    recv_stall_pct = 0;
    hold_off_req = ~hold_off_req;
    restart_sequence();
    for (int i = 0; i < 12; i++) begin
      if (i % 4 == 3) query_pair(16'h0010, 16'h0011);
      else append_symbol(16'h0010 + 16'(i % 2));
    end
    wait_for_results();
  endtask

  // Mostly well-formed sessions: a restart, a run of appends from a small
  // alphabet so that pairs repeat, and count requests that mostly name a
  // stored pair. Now and then a session runs past the end of the store.
  // The rest is noise with random selectors and fields.
  task automatic test_random_traffic(input int n_items, input int idle_pct,
                                     input int stall_pct);
    int          sent;
    int          run_len;
    int          pick;
    logic [15:0] base;
    logic [15:0] sym;
    logic [1:0]  kind;
    send_idle_pct = idle_pct;
    recv_stall_pct = stall_pct;
    sent = 0;
    while (sent < n_items) begin
      if ($urandom_range(9) == 0) begin
        kind = 2'($urandom_range(3));
        send_request(kind, 16'($urandom), 16'($urandom), 16'($urandom));
        sent++;
      end else begin
        restart_sequence();
        sent++;
        base = 16'($urandom);
        if ($urandom_range(59) == 0) run_len = $urandom_range(250, 262);
        else run_len = $urandom_range(0, 20);
        for (int k = 0; k < run_len; k++) begin
          if ($urandom_range(3) == 0) sym = 16'($urandom);
          else sym = base + 16'($urandom_range(3));
          append_symbol(sym);
          sent++;
          if ($urandom_range(3) == 0 || k == run_len - 1) begin
            if (seq_len >= 2 && $urandom_range(3) != 0) begin
              pick = $urandom_range(seq_len - 2);
              query_pair(seq_mem[pick], seq_mem[pick + 1]);
            end else begin
              query_pair(base + 16'($urandom_range(3)), 16'($urandom));
            end
            sent++;
          end
        end
      end
    end
    wait_for_results();
  endtask

  // Receiver: ready changes at the falling edge, either under a hold-off or
  // at the stall rate of the current phase.
  always @(negedge clk) begin
    if (hold_off_req != hold_off_seen) begin
      hold_off_seen = hold_off_req;
      hold_left = HOLD_OFF_CYCLES;
    end
    if (hold_left > 0) begin
      out_ready = 1'b0;
      hold_left--;
    end else begin
      out_ready = ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // Each result transfer is compared with the oldest prediction.
  always @(posedge clk) begin
    if (!rst && out_valid && out_ready) begin
      arrived = '{pair_count, total_bigrams, max_valid, max_first, max_second,
                  max_count, overflow};
      if (bigram_stats_q.size() == 0) begin
        $display("%0t: result transfer with nothing expected, actual %h",
                 $time, arrived);
        mismatch_count++;
      end else begin
        oldest = bigram_stats_q.pop_front();
        check_field("pair_count", oldest.pair_count, arrived.pair_count);
        check_field("total_bigrams", oldest.total_bigrams, arrived.total_bigrams);
        check_field("max_valid", oldest.max_valid, arrived.max_valid);
        check_field("max_first", oldest.max_first, arrived.max_first);
        check_field("max_second", oldest.max_second, arrived.max_second);
        check_field("max_count", oldest.max_count, arrived.max_count);
        check_field("overflow", oldest.overflow, arrived.overflow);
      end
    end
  end

  // Watchdog: any transfer on either channel restarts the count.
  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready)) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $display("%0t: no transfer for %0d cycles, %0d results outstanding",
                 $time, quiet_cycles, bigram_stats_q.size());
        $display("FAIL");
        $finish;
      end
    end
  end

  initial begin
    repeat (10) @(negedge clk);
    rst = 1'b0;

    test_empty_and_unused();
    test_pair_ordering();
    test_store_full();
    test_backpressure();
    // Idling phases: none, sender only, receiver only, then both together.
    test_random_traffic(225, 0, 0);
    test_random_traffic(225, 70, 0);
    test_random_traffic(225, 0, 70);
    test_random_traffic(225, 28, 28);

    wait_for_results();
    repeat (TAIL_CYCLES) @(negedge clk);
    if (mismatch_count == 0 && bigram_stats_q.size() == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule

@@ files.f @@
+incdir+design
design/bfc_pkg.sv
design/bfc_ram.sv
design/bfc_datapath.sv
design/bfc_controller.sv
design/bigram_frequency_counter.sv
tb/bigram_frequency_counter_tb.sv
